@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the pixel normalizer checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define WPN_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wpn assertion failed");

// Next-cycle implication, disabled during reset
`define WPN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wpn assertion failed");

`endif

@@ hw/rtl/wpn_pkg.sv @@
// ---------------------------------------------------------------------------
// wpn_pkg
// Shared constants and types of the weighted pixel normalizer.
// ---------------------------------------------------------------------------
package wpn_pkg;

   // Default widths
   localparam int VALUE_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;

   // Channel mode codes
   localparam logic [1:0] MODE_SCALAR = 2'd0;
   localparam logic [1:0] MODE_FLOW   = 2'd1;
   localparam logic [1:0] MODE_RGB    = 2'd2;

   // Register index codes
   localparam logic REG_CHANNEL_MODE     = 1'b0;
   localparam logic REG_WEIGHT_THRESHOLD = 1'b1;

   // Divider lane control
   typedef struct packed {
      logic load;
      logic step;
   } lane_ctrl_type;

endpackage

@@ hw/rtl/wpn_req_if.sv @@
// ---------------------------------------------------------------------------
// wpn_req_if
// Request channel: channel sums, weight, row start and edge values.
// ---------------------------------------------------------------------------
interface wpn_req_if #(
   parameter int VALUE_WIDTH = wpn_pkg::VALUE_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] val_a;
   logic signed [VALUE_WIDTH-1:0] val_b;
   logic signed [VALUE_WIDTH-1:0] val_c;
   logic        [VALUE_WIDTH-1:0] weight;
   logic                          row_start;
   logic signed [VALUE_WIDTH-1:0] edge_a;
   logic signed [VALUE_WIDTH-1:0] edge_b;

   modport source (
      output valid, val_a, val_b, val_c, weight, row_start, edge_a, edge_b,
      input  ready
   );
   modport sink (
      input  valid, val_a, val_b, val_c, weight, row_start, edge_a, edge_b,
      output ready
   );
endinterface

@@ hw/rtl/wpn_rsp_if.sv @@
// ---------------------------------------------------------------------------
// wpn_rsp_if
// Result channel: normalized channels and status flags.
// ---------------------------------------------------------------------------
interface wpn_rsp_if #(
   parameter int VALUE_WIDTH = wpn_pkg::VALUE_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] out_a;
   logic signed [VALUE_WIDTH-1:0] out_b;
   logic signed [VALUE_WIDTH-1:0] out_c;
   logic                          weight_flag;
   logic                          saturated;

   modport source (
      output valid, out_a, out_b, out_c, weight_flag, saturated,
      input  ready
   );
   modport sink (
      input  valid, out_a, out_b, out_c, weight_flag, saturated,
      output ready
   );
endinterface

@@ hw/rtl/weighted_pixel_normalizer_core.sv @@
// ---------------------------------------------------------------------------
// weighted_pixel_normalizer_core
// Divides splatted channel sums by their weight, with flow-mode hold fill.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake          Carries
// req       in         valid/ready        val_a..c, weight, row_start, edges
// rsp       out        valid/ready        out_a..c, weight_flag, saturated
// csr       in/out     APB psel/penable   channel_mode, weight_threshold
//
// A divided request steps three shared-control divider lanes, which retire
// one quotient bit per cycle; an undivided request skips the divide state.
// Reset clears the sequencer, the output register, the hold values and the
// registers. A stalled result waits in the output register; the next
// request is taken meanwhile and finishes once the result has been taken.
// ---------------------------------------------------------------------------
module weighted_pixel_normalizer_core #(
   parameter int VALUE_WIDTH = wpn_pkg::VALUE_WIDTH_DEF,
   parameter int FRAC_BITS   = wpn_pkg::FRAC_BITS_DEF,
   localparam int CSR_DATA_WIDTH = (VALUE_WIDTH > 32) ? 64 : 32,
   localparam int CSR_ADDR_WIDTH = (VALUE_WIDTH > 32) ? 4 : 3
) (
   input  logic                      clock,
   input  logic                      reset,
   wpn_req_if.sink                   req,
   wpn_rsp_if.source                 rsp,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);
   localparam int VW        = VALUE_WIDTH;
   localparam int STEPS     = VALUE_WIDTH + FRAC_BITS;
   localparam int CNT_WIDTH = $clog2(STEPS);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_FIN  = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [1:0]             channel_mode;
   logic [VW-1:0]          weight_threshold;
   logic                   accept;
   logic                   divide;
   logic                   fin_go;
   wpn_pkg::lane_ctrl_type lane_ctrl;

   logic                   flag_ff;
   logic                   rs_ff;
   logic [VW-1:0]          edge_a_ff, edge_b_ff;
   logic [VW-1:0]          divisor_ff;
   logic [VW-1:0]          hold_a_ff, hold_a_in;
   logic [VW-1:0]          hold_b_ff, hold_b_in;

   logic [VW-1:0]          quo_a, quo_b, quo_c;
   logic                   sat_a, sat_b, sat_c;
   logic [VW-1:0]          res_a, res_b, res_c;
   logic                   res_sat;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]          out_a_ff, out_b_ff, out_c_ff;
   logic                   flag_out_ff, sat_out_ff;

   // Configuration registers
   wpn_csr #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .DATA_WIDTH  (CSR_DATA_WIDTH),
      .ADDR_WIDTH  (CSR_ADDR_WIDTH)
   ) u_csr (
      .clock            (clock),
      .reset            (reset),
      .psel             (csr_psel),
      .penable          (csr_penable),
      .pwrite           (csr_pwrite),
      .paddr            (csr_paddr),
      .pwdata           (csr_pwdata),
      .prdata           (csr_prdata),
      .pready           (csr_pready),
      .channel_mode     (channel_mode),
      .weight_threshold (weight_threshold)
   );

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid & req.ready;
   assign divide    = req.weight > weight_threshold;
   assign fin_go    = (state_ff == ST_FIN) & (~rsp_valid_ff | rsp.ready);

   assign lane_ctrl.load = accept;
   assign lane_ctrl.step = (state_ff == ST_DIV);

   // Sequence: accept, step the lanes, then finish into the output register
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = divide ? ST_DIV : ST_FIN;
               cnt_in   = CNT_WIDTH'(STEPS - 1);
            end
         end
         ST_DIV: begin
            cnt_in = cnt_ff - {{(CNT_WIDTH-1){1'b0}}, 1'b1};
            if (cnt_ff == '0) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (fin_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Capture request side data
   always_ff @(posedge clock) begin
      if (accept) begin
         flag_ff    <= divide;
         rs_ff      <= req.row_start;
         edge_a_ff  <= req.edge_a;
         edge_b_ff  <= req.edge_b;
         divisor_ff <= req.weight;
      end
   end

   // Divider lanes
   wpn_div_lane #(.VALUE_WIDTH(VALUE_WIDTH)) u_lane_a (
      .clock     (clock),
      .ctrl      (lane_ctrl),
      .sum       (req.val_a),
      .divisor   (divisor_ff),
      .quotient  (quo_a),
      .saturated (sat_a)
   );

   wpn_div_lane #(.VALUE_WIDTH(VALUE_WIDTH)) u_lane_b (
      .clock     (clock),
      .ctrl      (lane_ctrl),
      .sum       (req.val_b),
      .divisor   (divisor_ff),
      .quotient  (quo_b),
      .saturated (sat_b)
   );

   wpn_div_lane #(.VALUE_WIDTH(VALUE_WIDTH)) u_lane_c (
      .clock     (clock),
      .ctrl      (lane_ctrl),
      .sum       (req.val_c),
      .divisor   (divisor_ff),
      .quotient  (quo_c),
      .saturated (sat_c)
   );

   // Select results by mode
   always_comb begin
      res_a   = '0;
      res_b   = '0;
      res_c   = '0;
      res_sat = 1'b0;
      case (channel_mode)
         wpn_pkg::MODE_FLOW: begin
            if (flag_ff) begin
               res_a   = quo_a;
               res_b   = quo_b;
               res_sat = sat_a | sat_b;
            end else begin
               res_a = rs_ff ? edge_a_ff : hold_a_ff;
               res_b = rs_ff ? edge_b_ff : hold_b_ff;
            end
         end
         wpn_pkg::MODE_RGB: begin
            if (flag_ff) begin
               res_a   = quo_a;
               res_b   = quo_b;
               res_c   = quo_c;
               res_sat = sat_a | sat_b | sat_c;
            end
         end
         default: begin
            if (flag_ff) begin
               res_a   = quo_a;
               res_sat = sat_a;
            end
         end
      endcase
   end

   // Advance the hold values with every finished request
   always_comb begin
      hold_a_in = fin_go ? res_a : hold_a_ff;
      hold_b_in = fin_go ? res_b : hold_b_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_a_ff <= '0;
         hold_b_ff <= '0;
      end else begin
         hold_a_ff <= hold_a_in;
         hold_b_ff <= hold_b_in;
      end
   end

   // Output register
   always_comb begin
      if (fin_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_go) begin
         out_a_ff    <= res_a;
         out_b_ff    <= res_b;
         out_c_ff    <= res_c;
         flag_out_ff <= flag_ff;
         sat_out_ff  <= res_sat;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_a       = out_a_ff;
   assign rsp.out_b       = out_b_ff;
   assign rsp.out_c       = out_c_ff;
   assign rsp.weight_flag = flag_out_ff;
   assign rsp.saturated   = sat_out_ff;
endmodule

@@ hw/rtl/wpn_div_lane.sv @@
// ---------------------------------------------------------------------------
// wpn_div_lane
// Restoring radix-2 divider lane: one quotient bit per step, sign-magnitude
// with saturation to the value width.
// ---------------------------------------------------------------------------
module wpn_div_lane #(
   parameter int VALUE_WIDTH = wpn_pkg::VALUE_WIDTH_DEF
) (
   input  logic                    clock,
   input  wpn_pkg::lane_ctrl_type  ctrl,
   input  logic [VALUE_WIDTH-1:0]  sum,
   input  logic [VALUE_WIDTH-1:0]  divisor,
   output logic [VALUE_WIDTH-1:0]  quotient,
   output logic                    saturated
);
   localparam int VW = VALUE_WIDTH;

   logic          neg_ff, neg_in;
   logic [VW-1:0] num_ff, num_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] quo_ff, quo_in;
   logic          over_ff, over_in;
   logic [VW+1:0] trial;
   logic          ge;
   logic [VW-1:0] limit;
   logic [VW-1:0] mag_q;

   // Shift one dividend bit into the partial remainder and try a subtract
   always_comb begin
      trial = {1'b0, rem_ff, num_ff[VW-1]} - {2'b00, divisor};
      ge    = ~trial[VW+1];
      neg_in  = neg_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      over_in = over_ff;
      if (ctrl.load) begin
         neg_in  = sum[VW-1];
         num_in  = sum[VW-1] ? (~sum + {{(VW-1){1'b0}}, 1'b1}) : sum;
         rem_in  = '0;
         quo_in  = '0;
         over_in = 1'b0;
      end else if (ctrl.step) begin
         num_in  = {num_ff[VW-2:0], 1'b0};
         rem_in  = ge ? trial[VW-1:0] : {rem_ff[VW-2:0], num_ff[VW-1]};
         quo_in  = {quo_ff[VW-2:0], ge};
         // Remember any quotient bit pushed past the top
         over_in = over_ff | quo_ff[VW-1];
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      over_ff <= over_in;
   end

   // Clamp the magnitude and apply the sign
   always_comb begin
      saturated = over_ff | (quo_ff[VW-1] & (~neg_ff | (|quo_ff[VW-2:0])));
      limit     = {neg_ff, {(VW-1){~neg_ff}}};
      mag_q     = saturated ? limit : quo_ff;
      quotient  = neg_ff ? (~mag_q + {{(VW-1){1'b0}}, 1'b1}) : mag_q;
   end
endmodule

@@ hw/rtl/wpn_csr.sv @@
// ---------------------------------------------------------------------------
// wpn_csr
// APB-style register file: channel mode and weight threshold.
// ---------------------------------------------------------------------------
module wpn_csr #(
   parameter int VALUE_WIDTH = wpn_pkg::VALUE_WIDTH_DEF,
   parameter int DATA_WIDTH  = 32,
   parameter int ADDR_WIDTH  = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [ADDR_WIDTH-1:0]  paddr,
   input  logic [DATA_WIDTH-1:0]  pwdata,
   output logic [DATA_WIDTH-1:0]  prdata,
   output logic                   pready,
   output logic [1:0]             channel_mode,
   output logic [VALUE_WIDTH-1:0] weight_threshold
);
   logic                   reg_index;
   logic                   wr_en;
   logic [1:0]             mode_ff, mode_in;
   logic [VALUE_WIDTH-1:0] thresh_ff, thresh_in;

   assign pready    = 1'b1;
   assign reg_index = paddr[ADDR_WIDTH-1];
   assign wr_en     = psel & penable & pwrite;

   // Decode writes
   always_comb begin
      mode_in   = mode_ff;
      thresh_in = thresh_ff;
      if (wr_en) begin
         case (reg_index)
            wpn_pkg::REG_CHANNEL_MODE:     mode_in   = pwdata[1:0];
            wpn_pkg::REG_WEIGHT_THRESHOLD: thresh_in = pwdata[VALUE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= wpn_pkg::MODE_SCALAR;
         thresh_ff <= '0;
      end else begin
         mode_ff   <= mode_in;
         thresh_ff <= thresh_in;
      end
   end

   // Read back
   always_comb begin
      case (reg_index)
         wpn_pkg::REG_CHANNEL_MODE:     prdata = DATA_WIDTH'(mode_ff);
         wpn_pkg::REG_WEIGHT_THRESHOLD: prdata = DATA_WIDTH'(thresh_ff);
         default:                       prdata = '0;
      endcase
   end

   assign channel_mode     = mode_ff;
   assign weight_threshold = thresh_ff;
endmodule

@@ hw/rtl/wpn_checker.sv @@
// ---------------------------------------------------------------------------
// wpn_checker
// Port-level checks of the pixel normalizer, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wpn_checker #(
   parameter int VALUE_WIDTH = wpn_pkg::VALUE_WIDTH_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [VALUE_WIDTH-1:0] rsp_out_a,
   input logic [VALUE_WIDTH-1:0] rsp_out_b,
   input logic [VALUE_WIDTH-1:0] rsp_out_c,
   input logic                   rsp_weight_flag,
   input logic                   rsp_saturated
);
   logic [3*VALUE_WIDTH+1:0] rsp_payload;

   // Gather the result fields into one vector
   assign rsp_payload = {rsp_out_a, rsp_out_b, rsp_out_c, rsp_weight_flag, rsp_saturated};

   // A stalled result holds
   `WPN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // One request in flight at a time
   `WPN_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)

   // No saturation without a division
   `WPN_ASSERT_NOW(a_sat_needs_div, clock, reset, rsp_valid && !rsp_weight_flag, !rsp_saturated)

   // Third channel is zero without a division
   `WPN_ASSERT_NOW(a_c_zero_undiv, clock, reset, rsp_valid && !rsp_weight_flag, rsp_out_c == '0)
endmodule

bind weighted_pixel_normalizer_core wpn_checker #(
   .VALUE_WIDTH (VALUE_WIDTH)
) u_wpn_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_out_a       (rsp.out_a),
   .rsp_out_b       (rsp.out_b),
   .rsp_out_c       (rsp.out_c),
   .rsp_weight_flag (rsp.weight_flag),
   .rsp_saturated   (rsp.saturated)
);

@@ tb/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for weighted_pixel_normalizer_core. A directed table
// covers the field extremes, every channel mode, saturation, threshold
// edges and flow-mode hold and row-start fill. Random phases under several
// register settings follow. Every result is compared with a known value or a
// local normalizer, and both channels idle and stall at random.
// ---------------------------------------------------------------------------
module testbench;

   localparam int VW = wpn_pkg::VALUE_WIDTH_DEF;
   localparam int FB = wpn_pkg::FRAC_BITS_DEF;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int STUCK_LIMIT = 2000;
   localparam int PHASES = 9;

   typedef struct packed {
      logic signed [VW-1:0] val_a;
      logic signed [VW-1:0] val_b;
      logic signed [VW-1:0] val_c;
      logic        [VW-1:0] weight;
      logic                 row_start;
      logic signed [VW-1:0] edge_a;
      logic signed [VW-1:0] edge_b;
   } pixel_req_type;

   typedef struct packed {
      logic signed [VW-1:0] out_a;
      logic signed [VW-1:0] out_b;
      logic signed [VW-1:0] out_c;
      logic                 weight_flag;
      logic                 saturated;
   } pixel_rsp_type;

   typedef struct packed {
      logic [1:0]    mode;
      logic [VW-1:0] threshold;
      pixel_req_type px;
      logic          known;
      pixel_rsp_type known_rsp;
   } pixel_case_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   wpn_req_if req_bus ();
   wpn_rsp_if rsp_bus ();

   weighted_pixel_normalizer_core dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Local copy of the registers and the flow-mode hold values
   logic [1:0]    cfg_mode;
   logic [VW-1:0] cfg_threshold;
   logic [VW-1:0] held_a;
   logic [VW-1:0] held_b;

   pixel_rsp_type normalized_queue [$];
   int            error_count;
   int            stuck_cycles;
   bit            send_idle_on;

   // Directed requests; known results only where they are obvious
   pixel_case_type directed_cases [0:20] = '{
      '{wpn_pkg::MODE_SCALAR, 32'h0000_0000,
        '{32'h0000_0005, 32'h0, 32'h0, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
        1'b1, '{32'h0, 32'h0, 32'h0, 1'b0, 1'b0}},
      '{wpn_pkg::MODE_SCALAR, 32'h0000_0000,
        '{32'h0003_0000, 32'h0, 32'h0, 32'h0001_0000, 1'b0, 32'h0, 32'h0},
        1'b1, '{32'h0003_0000, 32'h0, 32'h0, 1'b1, 1'b0}},
      '{wpn_pkg::MODE_SCALAR, 32'h0000_0000,
        '{32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0000_0001, 1'b0, 32'h0, 32'h0},
        1'b1, '{32'h7FFF_FFFF, 32'h0, 32'h0, 1'b1, 1'b1}},
      '{wpn_pkg::MODE_SCALAR, 32'h0000_0000,
        '{32'h8000_0000, 32'h0, 32'h0, 32'h0000_0001, 1'b0, 32'h0, 32'h0},
        1'b1, '{32'h8000_0000, 32'h0, 32'h0, 1'b1, 1'b1}},
      '{wpn_pkg::MODE_SCALAR, 32'h0000_0000,
        '{32'h8000_0000, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
        1'b0, '0},
      '{wpn_pkg::MODE_SCALAR, 32'h0000_0000,
        '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0002_0000, 1'b0, 32'h0, 32'h0},
        1'b0, '0},
      '{wpn_pkg::MODE_SCALAR, 32'h0000_0000,
        '{32'h7FFF_FFFF, 32'h1234, 32'h5678, 32'hFFFF_FFFF, 1'b1, 32'h0, 32'h0},
        1'b0, '0},
      '{wpn_pkg::MODE_SCALAR, 32'hFFFF_FFFF,
        '{32'h0000_0001, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
        1'b1, '{32'h0, 32'h0, 32'h0, 1'b0, 1'b0}},
      '{wpn_pkg::MODE_FLOW, 32'h0001_0000,
        '{32'h0005_0000, 32'h0006_0000, 32'h0, 32'h0001_0000, 1'b1,
          32'h1111_1111, 32'h8000_0000},
        1'b1, '{32'h1111_1111, 32'h8000_0000, 32'h0, 1'b0, 1'b0}},
      '{wpn_pkg::MODE_FLOW, 32'h0001_0000,
        '{32'h0, 32'h0, 32'h0, 32'h0000_0000, 1'b0, 32'h7FFF_FFFF, 32'h1},
        1'b0, '0},
      '{wpn_pkg::MODE_FLOW, 32'h0001_0000,
        '{32'h0004_0000, 32'hFFFC_0000, 32'h0007_0000, 32'h0002_0000, 1'b0,
          32'h0, 32'h0},
        1'b1, '{32'h0002_0000, 32'hFFFE_0000, 32'h0, 1'b1, 1'b0}},
      '{wpn_pkg::MODE_FLOW, 32'h0001_0000,
        '{32'h0, 32'h0, 32'h0, 32'h0000_0005, 1'b0, 32'h5555_5555, 32'h0},
        1'b0, '0},
      '{wpn_pkg::MODE_FLOW, 32'h0001_0000,
        '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0001_0001, 1'b0, 32'h0, 32'h0},
        1'b0, '0},
      '{wpn_pkg::MODE_FLOW, 32'h0001_0000,
        '{32'h0, 32'h0, 32'h0, 32'h0000_FFFF, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF},
        1'b1, '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0}},
      '{wpn_pkg::MODE_RGB, 32'h0000_0000,
        '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0, 1'b0, 32'h0, 32'h0},
        1'b1, '{32'h0, 32'h0, 32'h0, 1'b0, 1'b0}},
      '{wpn_pkg::MODE_RGB, 32'h0000_0000,
        '{32'h0001_2345, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h0001_0000, 1'b0,
          32'h0, 32'h0},
        1'b1, '{32'h0001_2345, 32'hFFFF_0000, 32'h7FFF_FFFF, 1'b1, 1'b0}},
      '{wpn_pkg::MODE_RGB, 32'h0000_0000,
        '{32'h0000_8000, 32'hFFFF_8000, 32'h8000_0000, 32'h0000_8000, 1'b0,
          32'h0, 32'h0},
        1'b0, '0},
      '{wpn_pkg::MODE_RGB, 32'h0000_0000,
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0,
          32'h0, 32'h0},
        1'b0, '0},
      '{MODE_UNUSED, 32'h0000_0000,
        '{32'h1234_5678, 32'h1111_0000, 32'h2222_0000, 32'h0001_0000, 1'b0,
          32'h0, 32'h0},
        1'b1, '{32'h1234_5678, 32'h0, 32'h0, 1'b1, 1'b0}},
      '{MODE_UNUSED, 32'h0000_0000,
        '{32'h1234_5678, 32'h0, 32'h0, 32'h0000_0000, 1'b1, 32'h1, 32'h1},
        1'b1, '{32'h0, 32'h0, 32'h0, 1'b0, 1'b0}},
      '{wpn_pkg::MODE_FLOW, 32'h0000_0000,
        '{32'h0, 32'h0, 32'h0, 32'h0000_0000, 1'b0, 32'h3, 32'h4},
        1'b0, '0}
   };

   // Signed Q16.16 sum over unsigned weight; top bit flags a clamp
   function automatic logic [VW:0] divide_channel(input logic [VW-1:0] sum,
                                                  input logic [VW-1:0] w);
      logic             neg;
      logic             clamp;
      logic [VW-1:0]    abs_sum;
      logic [VW-1:0]    mag_q;
      logic [VW+FB-1:0] quot;
      logic [VW+FB-1:0] lim;
      neg = sum[VW-1];
      abs_sum = neg ? -sum : sum;
      quot = {abs_sum, {FB{1'b0}}} / {{FB{1'b0}}, w};
      lim = {{FB{1'b0}}, 1'b1, {(VW-1){1'b0}}};
      if (!neg) begin
         lim = lim - 1'b1;
      end
      clamp = quot > lim;
      if (clamp) begin
         quot = lim;
      end
      mag_q = quot[VW-1:0];
      return {clamp, neg ? -mag_q : mag_q};
   endfunction

   // Normalize one pixel and advance the hold values
   function automatic pixel_rsp_type normalize_pixel(input pixel_req_type px);
      pixel_rsp_type r;
      logic [VW:0]   qa;
      logic [VW:0]   qb;
      logic [VW:0]   qc;
      logic          divide;
      r = '0;
      divide = px.weight > cfg_threshold;
      if (divide) begin
         qa = divide_channel(px.val_a, px.weight);
         qb = divide_channel(px.val_b, px.weight);
         qc = divide_channel(px.val_c, px.weight);
      end
      case (cfg_mode)
         wpn_pkg::MODE_FLOW: begin
            if (divide) begin
               r.out_a = qa[VW-1:0];
               r.out_b = qb[VW-1:0];
               r.saturated = qa[VW] | qb[VW];
            end else begin
               r.out_a = px.row_start ? px.edge_a : held_a;
               r.out_b = px.row_start ? px.edge_b : held_b;
            end
         end
         wpn_pkg::MODE_RGB: begin
            if (divide) begin
               r.out_a = qa[VW-1:0];
               r.out_b = qb[VW-1:0];
               r.out_c = qc[VW-1:0];
               r.saturated = qa[VW] | qb[VW] | qc[VW];
            end
         end
         default: begin
            if (divide) begin
               r.out_a = qa[VW-1:0];
               r.saturated = qa[VW];
            end
         end
      endcase
      r.weight_flag = divide;
      held_a = r.out_a;
      held_b = r.out_b;
      return r;
   endfunction

   // Gap length: mostly none or short, a few long
   function automatic int unsigned pick_gap(input bit enabled);
      int unsigned r;
      if (!enabled) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 50) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 60);
   endfunction

   function automatic logic [VW-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
         default: return $urandom;
      endcase
   endfunction

   // Bias weights toward the threshold edge; flow mode gets more holds
   function automatic logic [VW-1:0] pick_weight();
      if (cfg_mode == wpn_pkg::MODE_FLOW && $urandom_range(0, 99) < 30) begin
         return $urandom_range(0, cfg_threshold);
      end
      case ($urandom_range(0, 9))
         0: return 32'h0;
         1: return cfg_threshold;
         2: return cfg_threshold + 1'b1;
         3: return $urandom_range(1, 32'hFF);
         4: return 32'hFFFF_FFFF;
         5: return $urandom_range(32'h0000_F000, 32'h0001_1000);
         default: return $urandom;
      endcase
   endfunction

   task automatic check_pixel(input pixel_rsp_type want, input pixel_rsp_type got);
      if (got.out_a !== want.out_a) begin
         $error("out_a: expected %h, actual %h", want.out_a, got.out_a);
         error_count++;
      end
      if (got.out_b !== want.out_b) begin
         $error("out_b: expected %h, actual %h", want.out_b, got.out_b);
         error_count++;
      end
      if (got.out_c !== want.out_c) begin
         $error("out_c: expected %h, actual %h", want.out_c, got.out_c);
         error_count++;
      end
      if (got.weight_flag !== want.weight_flag) begin
         $error("weight_flag: expected %b, actual %b", want.weight_flag,
                got.weight_flag);
         error_count++;
      end
      if (got.saturated !== want.saturated) begin
         $error("saturated: expected %b, actual %b", want.saturated, got.saturated);
         error_count++;
      end
   endtask

   // One APB transfer: setup, access, then idle
   task automatic csr_access(input logic write, input logic [2:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= addr;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Write a register, read it back and update the local copy
   task automatic write_register(input logic index, input logic [31:0] value);
      logic [31:0] rdata;
      logic [31:0] want;
      csr_access(1'b1, {index, 2'b00}, value, rdata);
      csr_access(1'b0, {index, 2'b00}, 32'h0, rdata);
      if (index == wpn_pkg::REG_CHANNEL_MODE) begin
         cfg_mode = value[1:0];
         want = 32'(value[1:0]);
      end else begin
         cfg_threshold = value;
         want = value;
      end
      if (rdata !== want) begin
         $error("csr_prdata: expected %h, actual %h", want, rdata);
         error_count++;
      end
   endtask

   // Drain all pending results, then write both registers
   task automatic apply_settings(input logic [1:0] mode, input logic [VW-1:0] thr);
      req_bus.valid <= 1'b0;
      while (normalized_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      write_register(wpn_pkg::REG_CHANNEL_MODE, 32'(mode));
      write_register(wpn_pkg::REG_WEIGHT_THRESHOLD, thr);
   endtask

   // Offer one request, wait for the handshake, queue its result
   task automatic send_pixel(input pixel_req_type px, input logic known,
                             input pixel_rsp_type known_rsp);
      int unsigned   gap;
      pixel_rsp_type predicted;
      gap = pick_gap(send_idle_on);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.val_a <= px.val_a;
      req_bus.val_b <= px.val_b;
      req_bus.val_c <= px.val_c;
      req_bus.weight <= px.weight;
      req_bus.row_start <= px.row_start;
      req_bus.edge_a <= px.edge_a;
      req_bus.edge_b <= px.edge_b;
      do @(posedge clock); while (!req_bus.ready);
      predicted = normalize_pixel(px);
      normalized_queue.push_back(known ? known_rsp : predicted);
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: end the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_psel && csr_penable && csr_pready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Result side: random stalls, compare each result with the oldest one queued
   initial begin
      int unsigned   stall_left;
      bit            stall_on;
      pixel_rsp_type got;
      stall_left = 0;
      stall_on = 1'b1;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.out_a = rsp_bus.out_a;
            got.out_b = rsp_bus.out_b;
            got.out_c = rsp_bus.out_c;
            got.weight_flag = rsp_bus.weight_flag;
            got.saturated = rsp_bus.saturated;
            if (normalized_queue.size() == 0) begin
               $error("result with no request pending: out_a %h", got.out_a);
               error_count++;
            end else begin
               check_pixel(normalized_queue.pop_front(), got);
            end
         end
         if ($urandom_range(0, 199) == 0) begin
            stall_on = !stall_on;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 99) < 30) begin
               stall_left = pick_gap(stall_on);
            end
         end
      end
   end

   // Request side and run control
   initial begin
      pixel_req_type px;
      logic [1:0]    phase_modes [PHASES];
      logic [VW-1:0] thr;
      int unsigned   row_left;
      int            count;
      phase_modes = '{wpn_pkg::MODE_FLOW, wpn_pkg::MODE_RGB, wpn_pkg::MODE_SCALAR,
                      wpn_pkg::MODE_FLOW, MODE_UNUSED, wpn_pkg::MODE_RGB,
                      wpn_pkg::MODE_FLOW, wpn_pkg::MODE_SCALAR, wpn_pkg::MODE_FLOW};
      error_count = 0;
      stuck_cycles = 0;
      send_idle_on = 1'b1;
      row_left = 0;
      cfg_mode = wpn_pkg::MODE_SCALAR;
      cfg_threshold = '0;
      held_a = '0;
      held_b = '0;
      reset <= 1'b1;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.val_a <= '0;
      req_bus.val_b <= '0;
      req_bus.val_c <= '0;
      req_bus.weight <= '0;
      req_bus.row_start <= 1'b0;
      req_bus.edge_a <= '0;
      req_bus.edge_b <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table; rewrite the registers only when a row needs it
      foreach (directed_cases[i]) begin
         if (directed_cases[i].mode != cfg_mode
             || directed_cases[i].threshold != cfg_threshold) begin
            apply_settings(directed_cases[i].mode, directed_cases[i].threshold);
         end
         send_pixel(directed_cases[i].px, directed_cases[i].known,
                    directed_cases[i].known_rsp);
      end

      // Random phases, each under its own register setting
      for (int p = 0; p < PHASES; p++) begin
         case ($urandom_range(0, 3))
            0: thr = 32'h0001_0000;
            1: thr = $urandom_range(0, 32'h0004_0000);
            2: thr = $urandom;
            default: thr = '0;
         endcase
         if (p == 0) begin
            thr = '0;
         end else if (p == 4) begin
            thr = '1;
         end
         apply_settings(phase_modes[p], thr);
         count = (p == 4) ? 40 : 120;
         for (int n = 0; n < count; n++) begin
            // Rows of random length, with an occasional misplaced row start
            if (row_left == 0) begin
               row_left = $urandom_range(1, 16);
               px.row_start = 1'b1;
            end else begin
               px.row_start = 1'b0;
            end
            row_left--;
            if ($urandom_range(0, 19) == 0) begin
               px.row_start = !px.row_start;
            end
            if ($urandom_range(0, 49) == 0) begin
               send_idle_on = !send_idle_on;
            end
            px.val_a = pick_value();
            px.val_b = pick_value();
            px.val_c = pick_value();
            px.weight = pick_weight();
            px.edge_a = pick_value();
            px.edge_b = pick_value();
            send_pixel(px, 1'b0, '0);
         end
      end

      // Drain all pending results, then wait before ending the run
      req_bus.valid <= 1'b0;
      while (normalized_queue.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
